// ===== hdl/skf_pkg.sv =====
// Shared package for the scalar Kalman filter: sequencer states, control
// bundle, opcodes and configuration register indexes.
// No dependencies.
`default_nettype none

package skf_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_PROCESS_NOISE     = 2'd0;
  localparam cfg_idx_t REG_MEASUREMENT_NOISE = 2'd1;
  localparam cfg_idx_t REG_INITIAL_ERROR     = 2'd2;
  localparam cfg_idx_t REG_INITIAL_VALUE     = 2'd3;

  typedef enum logic {
    OP_UPDATE  = 1'b0,
    OP_RESTART = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_MUL_EST,
    S_MUL_COV,
    S_COV_WB,
    S_OUT
  } skf_state_e;

  typedef struct packed {
    logic div_start;
    logic gain_wb;
    logic mul_cov;
    logic est_wb;
    logic cov_wb;
    logic out_load;
  } skf_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/scalar_kalman_filter.sv =====
// Scalar Kalman filter top level: sequencer, state registers and rounding.
// Update item: the bit-serial gain divider runs, the shared multiplier forms the estimate
// step and then the covariance scaling, and the output register is loaded. Restart item:
// loads the initial value and error, then the output register. One item at a time: the next item is
// taken only after the output register is loaded. Reset loads the register reset values at once; no clearing pass.
// Depends on skf_pkg, skf_div and skf_mul.
`default_nettype none

module scalar_kalman_filter #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned GAIN_BITS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // configuration write port
  input  wire logic                     cfg_we_i,
  input  wire skf_pkg::cfg_idx_t        cfg_index_i,
  input  wire logic [31:0]              cfg_data_i,
  // input channel
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [0:0]               op_i,
  input  wire logic signed [31:0]       sample_i,
  // output channel
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed [31:0]            estimate_o,
  output logic [GAIN_BITS:0]            gain_o,
  output logic [31:0]                   covariance_o
);

  import skf_pkg::*;

  localparam int unsigned GW = GAIN_BITS + 1;
  localparam int unsigned AW = DATA_W + 2;
  localparam int unsigned BW = GAIN_BITS + 2;
  localparam int unsigned PW = AW + BW;
  localparam int unsigned SW = PW - GAIN_BITS;

  localparam logic [DATA_W-1:0]    COV_ONE  = DATA_W'(1) << FRAC_BITS;
  localparam logic [GW-1:0]        GAIN_ONE = GW'(1) << GAIN_BITS;
  localparam logic signed [PW-1:0] RND_HALF = PW'(1) << (GAIN_BITS - 1);

  // configuration registers
  logic [DATA_W-1:0] proc_noise_q;
  logic [DATA_W-1:0] meas_noise_q;
  logic [DATA_W-1:0] init_error_q;
  logic [DATA_W-1:0] init_value_q;

  // filter state
  logic [DATA_W-1:0] est_q;
  logic [DATA_W-1:0] cov_q;

  // per-item working registers
  logic [DATA_W-1:0] sample_q;
  logic [DATA_W-1:0] p_q;
  logic [GW-1:0]     gain_q;

  // output register
  logic              out_valid_q;
  logic [DATA_W-1:0] out_est_q;
  logic [GW-1:0]     out_gain_q;
  logic [DATA_W-1:0] out_cov_q;

  skf_state_e state_q, state_d;
  skf_ctrl_t  ctrl;
  logic       accept;

  logic [DATA_W:0]        p_sum;
  logic [DATA_W-1:0]      p_sat;
  logic [DATA_W:0]        den;
  logic [DATA_W:0]        diff;
  logic [GW-1:0]          omg;
  logic signed [AW-1:0]   mul_a;
  logic signed [BW-1:0]   mul_b;
  logic signed [PW-1:0]   mul_p;
  logic signed [PW-1:0]   rnd;
  logic [SW-1:0]          step;
  logic [SW-1:0]          est_ext;
  logic [SW-1:0]          nx;
  logic                   nx_fits;
  logic [DATA_W-1:0]      est_new;
  logic [DATA_W-1:0]      cov_new;
  logic                   div_done;
  logic [GW-1:0]          div_quot;

  assign accept = in_valid_i && (state_q == S_IDLE);

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proc_noise_q <= '0;
      meas_noise_q <= COV_ONE;
      init_error_q <= COV_ONE;
      init_value_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_PROCESS_NOISE:     proc_noise_q <= cfg_data_i;
        REG_MEASUREMENT_NOISE: meas_noise_q <= cfg_data_i;
        REG_INITIAL_ERROR:     init_error_q <= cfg_data_i;
        REG_INITIAL_VALUE:     init_value_q <= cfg_data_i;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (op_i == OP_RESTART) ? S_OUT : S_PREP;
        end
      end
      S_PREP:    state_d = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_d = S_MUL_EST;
        end
      end
      S_MUL_EST: state_d = S_MUL_COV;
      S_MUL_COV: state_d = S_COV_WB;
      S_COV_WB:  state_d = S_OUT;
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state_q)
      S_IDLE:    ;
      S_PREP:    ctrl.div_start = 1'b1;
      S_DIV:     ctrl.gain_wb   = div_done;
      S_MUL_EST: ;
      S_MUL_COV: begin
        ctrl.mul_cov = 1'b1;
        ctrl.est_wb  = 1'b1;
      end
      S_COV_WB:  ctrl.cov_wb   = 1'b1;
      S_OUT:     ctrl.out_load = !out_valid_q || !out_stall_i;
      default:   ;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  // ---------------- datapath ----------------
  // Predict: p = cov + q, saturating.
  assign p_sum = {1'b0, cov_q} + {1'b0, proc_noise_q};
  assign p_sat = p_sum[DATA_W] ? '1 : p_sum[DATA_W-1:0];
  assign den   = {1'b0, p_q} + {1'b0, meas_noise_q};

  assign diff  = {sample_q[DATA_W-1], sample_q} - {est_q[DATA_W-1], est_q};
  assign omg   = GAIN_ONE - gain_q;

  assign mul_a = ctrl.mul_cov ? {2'b00, p_q} : {diff[DATA_W], diff};
  assign mul_b = ctrl.mul_cov ? {1'b0, omg} : {1'b0, gain_q};

  skf_div #(
    .GAIN_BITS(GAIN_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(ctrl.div_start),
    .num_i  (p_q),
    .den_i  (den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  skf_mul #(
    .AW(AW),
    .BW(BW)
  ) u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (mul_p)
  );

  // Round to nearest, ties up, then drop the gain fraction bits.
  assign rnd     = mul_p + RND_HALF;
  assign step    = rnd[PW-1:GAIN_BITS];
  assign est_ext = {{(SW-DATA_W){est_q[DATA_W-1]}}, est_q};
  assign nx      = est_ext + step;
  assign nx_fits = (&nx[SW-1:DATA_W-1]) || !(|nx[SW-1:DATA_W-1]);
  assign est_new = nx_fits ? nx[DATA_W-1:0]
                 : (nx[SW-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}});
  assign cov_new = (|step[SW-1:DATA_W]) ? '1 : step[DATA_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q <= '0;
      cov_q <= COV_ONE;
    end else if (accept && (op_i == OP_RESTART)) begin
      est_q <= init_value_q;
      cov_q <= init_error_q;
    end else begin
      if (ctrl.est_wb) begin
        est_q <= est_new;
      end
      if (ctrl.cov_wb) begin
        cov_q <= cov_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= sample_i;
      p_q      <= p_sat;
    end
    if (accept && (op_i == OP_RESTART)) begin
      gain_q <= '0;
    end else if (ctrl.gain_wb) begin
      gain_q <= div_quot;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      out_est_q  <= est_q;
      out_gain_q <= gain_q;
      out_cov_q  <= cov_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign estimate_o   = out_est_q;
  assign gain_o       = out_gain_q;
  assign covariance_o = out_cov_q;

endmodule

`default_nettype wire

// ===== hdl/skf_div.sv =====
// Restoring radix-2 divider for the filter gain: floor(num * 2^GAIN_BITS / den).
// One compare and subtract per cycle; a zero divisor yields zero.
// No package dependencies.
`default_nettype none

module skf_div #(
  parameter int unsigned GAIN_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [31:0]          num_i,
  input  wire logic [32:0]          den_i,
  output logic                      done_o,
  output logic [GAIN_BITS:0]        quot_o
);

  localparam int unsigned QW = GAIN_BITS + 1;
  localparam int unsigned CW = $clog2(GAIN_BITS + 2);

  logic [32:0]   rem_q;
  logic [32:0]   den_q;
  logic [QW-1:0] quot_q;
  logic          zero_q;
  logic          first_q;
  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;

  logic [33:0]   shifted;
  logic [33:0]   sub;
  logic          ge;

  // The first step compares the numerator unshifted; it yields the integer bit.
  assign shifted = first_q ? {1'b0, rem_q} : {rem_q, 1'b0};
  assign ge      = shifted >= {1'b0, den_q};
  assign sub     = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      first_q <= 1'b0;
      cnt_q   <= '0;
    end else if (start_i) begin
      busy_q  <= 1'b1;
      done_q  <= 1'b0;
      first_q <= 1'b1;
      cnt_q   <= CW'(GAIN_BITS + 1);
    end else if (busy_q) begin
      first_q <= 1'b0;
      cnt_q   <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, num_i};
      den_q  <= den_i;
      zero_q <= (den_i == '0);
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? sub[32:0] : shifted[32:0];
      quot_q <= {quot_q[QW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = zero_q ? '0 : quot_q;

endmodule

`default_nettype wire

// ===== hdl/skf_mul.sv =====
// Shared signed multiplier with a registered product, used for both the
// estimate step and the covariance scaling. No package dependencies.
`default_nettype none

module skf_mul #(
  parameter int unsigned AW = 34,
  parameter int unsigned BW = 18
) (
  input  wire logic                    clk_i,
  input  wire logic signed [AW-1:0]    a_i,
  input  wire logic signed [BW-1:0]    b_i,
  output logic signed [AW+BW-1:0]      p_o
);

  logic signed [AW+BW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ===== hdl/skf_chk.sv =====
// Port-level checker for scalar_kalman_filter, attached by bind.
// Depends on skf_pkg.
`default_nettype none

module skf_chk #(
  parameter int unsigned GAIN_BITS = 16
) (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_stall_o,
  input wire logic [0:0]           op_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire logic [GAIN_BITS:0]   gain_o
);

  import skf_pkg::*;

  localparam logic [GAIN_BITS:0] GAIN_ONE = (GAIN_BITS+1)'(1) << GAIN_BITS;

  // One item at a time: busy right after an item is taken.
  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again right after an item");

  // Restart with an empty output stage: a result follows with gain zero.
  a_restart_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (op_i == OP_RESTART) && !out_valid_o)
      |=> ##1 (out_valid_o && (gain_o == '0)))
    else $error("restart result missing or gain nonzero");

  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (gain_o <= GAIN_ONE))
    else $error("gain above one");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

endmodule

bind scalar_kalman_filter skf_chk #(
  .GAIN_BITS(GAIN_BITS)
) u_skf_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .op_i       (op_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .gain_o     (gain_o)
);

`default_nettype wire
